// File: hw/rtl/csi_rf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csi_rf_pkg;

    // largest payload a record may announce; longer lengths saturate here
    localparam int MAX_PAYLOAD = 256;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [31:0] FRAME_MAGIC = 32'h43534921;

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // byte sequencer positions: 0..12 are the header bytes
    localparam logic [4:0] IDX_HDR_FIRST = 5'd0;
    localparam logic [4:0] IDX_HDR_LAST  = 5'd12;
    localparam logic [4:0] IDX_CRC_LO    = 5'd15;
    localparam logic [4:0] IDX_CRC_HI    = 5'd16;
    localparam logic [4:0] IDX_DATA      = 5'd17;

    // per-item plan decided by the record tracker at accept time
    typedef struct packed {
        logic       emit;       // item produces output bytes
        logic       hdr;        // start item: header bytes, else one data byte
        logic       crc_after;  // the two CRC bytes follow
        logic [8:0] len;        // saturated payload length
    } t_plan;

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/csi_rf_track.sv
`timescale 1ns / 1ps
`default_nettype none

module csi_rf_track (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_take,
    input  wire                  i_operation,
    input  wire [8:0]            i_payload_length,
    output csi_rf_pkg::t_plan    o_plan
);
    import csi_rf_pkg::*;

    logic       r_open;
    logic [8:0] r_remaining;
    logic       n_open;
    logic [8:0] n_remaining;
    logic [8:0] len_sat;

    always_comb begin
        if (32'(i_payload_length) > MAX_PAYLOAD) begin
            len_sat = 9'(MAX_PAYLOAD);
        end else begin
            len_sat = i_payload_length;
        end

        o_plan      = '0;
        o_plan.len  = len_sat;
        n_open      = r_open;
        n_remaining = r_remaining;

        if (i_operation == OP_START) begin
            o_plan.emit      = 1'b1;
            o_plan.hdr       = 1'b1;
            o_plan.crc_after = (len_sat == 9'd0);
            n_open           = (len_sat != 9'd0);
            n_remaining      = len_sat;
        end else if (r_open && (r_remaining != 9'd0)) begin
            o_plan.emit      = 1'b1;
            o_plan.crc_after = (r_remaining == 9'd1);
            n_remaining      = r_remaining - 9'd1;
            n_open           = (r_remaining != 9'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= '0;
        end else if (i_take) begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/csi_rf_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module csi_rf_emit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    output logic                 o_take,
    input  csi_rf_pkg::t_plan    i_plan,
    input  wire [31:0]           i_round_number,
    input  wire [7:0]            i_sender_id,
    input  wire [7:0]            i_receiver_id,
    input  wire [7:0]            i_strength_byte,
    input  wire [7:0]            i_data_byte,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_frame_end
);
    import csi_rf_pkg::*;

    // sequencer control
    logic        r_busy;
    logic [4:0]  r_idx;
    logic        r_crc_after;
    logic [15:0] r_crc;
    // item payload
    logic [31:0] r_round;
    logic [7:0]  r_tx;
    logic [7:0]  r_rx;
    logic [7:0]  r_rssi;
    logic [8:0]  r_len;
    logic [7:0]  r_data;
    // result register
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_oend;

    logic        adv;
    logic        last;
    logic        fold;
    logic [7:0]  cur_byte;
    logic [4:0]  n_idx;
    logic [103:0] hdr;

    assign hdr = {7'd0, r_len[8], r_len[7:0], r_rssi, r_rx, r_tx, r_round, FRAME_MAGIC};

    always_comb begin
        adv  = r_busy && (!r_ovalid || !i_stall);
        last = (r_idx == IDX_CRC_HI) ||
               (((r_idx == IDX_HDR_LAST) || (r_idx == IDX_DATA)) && !r_crc_after);
        fold = (r_idx <= IDX_HDR_LAST) || (r_idx == IDX_DATA);

        case (r_idx)
            IDX_CRC_LO: cur_byte = r_crc[7:0];
            IDX_CRC_HI: cur_byte = r_crc[15:8];
            IDX_DATA:   cur_byte = r_data;
            default:    cur_byte = hdr[8 * r_idx[3:0] +: 8];
        endcase

        if ((r_idx == IDX_HDR_LAST) || (r_idx == IDX_DATA)) begin
            n_idx = IDX_CRC_LO;
        end else begin
            n_idx = r_idx + 5'd1;
        end

        o_stall = r_busy && !(adv && last);
        o_take  = i_valid && !o_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= IDX_HDR_FIRST;
            r_crc_after <= 1'b0;
            r_crc       <= CRC_INIT;
            r_ovalid    <= 1'b0;
        end else begin
            if (o_take && i_plan.emit) begin
                r_busy      <= 1'b1;
                r_idx       <= i_plan.hdr ? IDX_HDR_FIRST : IDX_DATA;
                r_crc_after <= i_plan.crc_after;
            end else if (adv) begin
                r_busy <= !last;
                r_idx  <= n_idx;
            end

            if (adv) begin
                if (r_idx == IDX_CRC_HI) begin
                    r_crc <= CRC_INIT;
                end else if (fold) begin
                    r_crc <= crc_byte((r_idx == IDX_HDR_FIRST) ? CRC_INIT : r_crc,
                                      cur_byte);
                end
            end

            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_plan.emit) begin
            r_round <= i_round_number;
            r_tx    <= i_sender_id;
            r_rx    <= i_receiver_id;
            r_rssi  <= i_strength_byte;
            r_len   <= i_plan.len;
            r_data  <= i_data_byte;
        end
        if (adv) begin
            r_obyte <= cur_byte;
            r_oend  <= (r_idx == IDX_CRC_HI);
        end
    end

    assign o_valid     = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_frame_end = r_oend;

endmodule

`default_nettype wire

// File: hw/rtl/csi_record_framer_crc16.sv
// Record framer for a serial byte link, with CRC-16 (poly 0x1021, init 0xFFFF).
// Input channel (i_valid / o_stall): one item per handshake. Operation start
//   opens a record and yields the 13-byte little-endian header (magic, round,
//   sender, receiver, strength, 16-bit length); operation data yields one
//   payload byte. After the last payload byte the CRC follows, low byte first,
//   with o_frame_end set on the high byte. A zero-length start closes at once.
//   Data items with no open record are taken and dropped; a start while a
//   record is open abandons it. Lengths above the maximum saturate.
// Output channel (o_valid / i_stall): one byte per handshake.
// Path: an item taken passes the item register, then the result register,
//   before its first byte shows on o_valid.
// Throughput: one byte per cycle from the byte sequencer unless i_stall holds
//   it; a data item yields 1 byte (3 with its CRC) and a start item 13 or 15 bytes.
//   The next item is taken in the cycle the last byte of the current one
//   moves into the result register.
// Reset (i_rst_n low, synchronous): no record open, CRC at 0xFFFF, output
//   empty. i_stall holds the result byte and the sequencer; o_stall stays high
//   while an item is held, until its last byte enters the result register.
`timescale 1ns / 1ps
`default_nettype none

module csi_record_framer_crc16 (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire               i_operation,
    input  wire [31:0]        i_round_number,
    input  wire [7:0]         i_sender_id,
    input  wire [7:0]         i_receiver_id,
    input  wire signed [7:0]  i_signal_strength,
    input  wire [8:0]         i_payload_length,
    input  wire [7:0]         i_data_byte,
    output logic              o_valid,
    input  wire               i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_frame_end
);
    import csi_rf_pkg::*;

    t_plan plan;
    logic  take;

    // record state: open flag and bytes still expected, decided per item
    csi_rf_track u_track (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (take),
        .i_operation      (i_operation),
        .i_payload_length (i_payload_length),
        .o_plan           (plan)
    );

    // byte sequencer with running CRC and result register
    csi_rf_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .o_take          (take),
        .i_plan          (plan),
        .i_round_number  (i_round_number),
        .i_sender_id     (i_sender_id),
        .i_receiver_id   (i_receiver_id),
        .i_strength_byte ($unsigned(i_signal_strength)),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_frame_end     (o_frame_end)
    );

endmodule

`default_nettype wire
